// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the telegram framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtfc_pkg.sv =====
// Shared types, constants and helper functions of the meter telegram framer.
package mtfc_pkg;

    localparam int MaxLines      = 256;
    localparam int MaxLineLength = 4096;

    localparam logic [7:0]  LineTop = 8'((MaxLines - 1) < 255 ? (MaxLines - 1) : 255);
    localparam logic [11:0] ColTop  =
        12'((MaxLineLength - 1) < 4095 ? (MaxLineLength - 1) : 4095);

    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChBang  = 8'h21;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;

    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [2:0]  CrcDigits = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_SEPARATOR = 3'd2,
        PH_DATA      = 3'd3,
        PH_END       = 3'd4,
        PH_CRC       = 3'd5,
        PH_TRAILER   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_PAYLOAD    = 3'd0,
        EV_LINE_END   = 3'd1,
        EV_ACCEPT     = 3'd2,
        EV_MISMATCH   = 3'd3,
        EV_UNEXPECTED = 3'd4
    } t_event;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    // Decodes an ASCII hex digit in either case.
    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            h.value = 4'(b - 8'h30);
        end else if (b inside {[8'h41:8'h46]}) begin
            h.value = 4'(b - 8'h37);
        end else if (b inside {[8'h61:8'h66]}) begin
            h.value = 4'(b - 8'h57);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/mtfc_crc16_byte.sv =====
// Byte-wide CRC-16/ARC update (reflected, polynomial 0xA001).
module mtfc_crc16_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mtfc_pkg::CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// ===== rtl/meter_telegram_framer_crc.sv =====
// Top level of the meter telegram framer with CRC-16 check.
// A byte accepted into the input register presents its event from the result register once that stage can advance.
// Throughput: one byte per cycle while the output is not stalled; the framing state and the byte-wide CRC
// update finish between the input register and the result register.
// Reset: synchronous, active low; it clears the phase, counters, CRC and
// the CRC bypass bit, and both pipeline stages come out empty.
`include "assert_macros.svh"

module meter_telegram_framer_crc (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [15:8] line_index, [27:16] column_index,
    // [43:28] computed_crc, [59:44] received_crc, [63:60] zero
    output logic [63:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // [0] crc_bypass
);

    // Configuration
    logic r_crc_bypass;

    // Input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Framing state
    mtfc_pkg::t_phase r_phase, n_phase;
    logic        r_line_start;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_rx_crc, n_rx_crc;
    logic [2:0]  r_digit_cnt, n_digit_cnt;
    logic        r_parse_stop, n_parse_stop;
    logic [7:0]  r_line_cnt, n_line_cnt;
    logic [11:0] r_col_cnt, n_col_cnt;

    // Result stage
    logic             r_out_valid;
    mtfc_pkg::t_event r_out_kind;
    logic [7:0]       r_out_byte;
    logic [7:0]       r_out_line;
    logic [11:0]      r_out_col;
    logic [15:0]      r_out_ccrc;
    logic [15:0]      r_out_rcrc;

    logic             n_emit;
    mtfc_pkg::t_event n_kind;
    logic [11:0]      n_col;
    logic [15:0]      n_ccrc;
    logic [15:0]      n_rcrc;

    logic        adv;
    logic        do_step;
    logic [7:0]  b;
    logic        is_lf, is_cr, is_slash, is_bang;
    logic        idle_like;
    logic [15:0] crc_seed;
    logic [15:0] crc_upd;
    logic        crc_ok;
    mtfc_pkg::t_hex hex;

    assign adv     = !r_out_valid || m_axis_tready;
    assign do_step = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    assign b        = r_in_byte;
    assign is_lf    = (b == mtfc_pkg::ChLf);
    assign is_cr    = (b == mtfc_pkg::ChCr);
    assign is_slash = (b == mtfc_pkg::ChSlash);
    assign is_bang  = (b == mtfc_pkg::ChBang);
    assign hex      = mtfc_pkg::hex_decode(b);

    // Idle, trailer and the unused code all restart the CRC from zero on '/'.
    assign idle_like = !(r_phase inside {mtfc_pkg::PH_HEADER, mtfc_pkg::PH_SEPARATOR,
                                         mtfc_pkg::PH_DATA, mtfc_pkg::PH_END,
                                         mtfc_pkg::PH_CRC});
    assign crc_seed  = idle_like ? 16'h0000 : r_crc;

    mtfc_crc16_byte u_crc (
        .i_crc  (crc_seed),
        .i_byte (b),
        .o_crc  (crc_upd)
    );

    assign crc_ok = r_crc_bypass || (r_phase == mtfc_pkg::PH_END) || (r_crc == r_rx_crc);

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_crc        = r_crc;
        n_rx_crc     = r_rx_crc;
        n_digit_cnt  = r_digit_cnt;
        n_parse_stop = r_parse_stop;
        n_line_cnt   = r_line_cnt;
        n_col_cnt    = r_col_cnt;
        case (r_phase)
            mtfc_pkg::PH_HEADER: begin
                n_crc = crc_upd;
                if (is_lf) begin
                    n_phase = mtfc_pkg::PH_SEPARATOR;
                end
            end
            mtfc_pkg::PH_SEPARATOR: begin
                n_crc = crc_upd;
                if (is_lf) begin
                    n_phase = mtfc_pkg::PH_DATA;
                end
            end
            mtfc_pkg::PH_DATA: begin
                n_crc = crc_upd;
                if (is_bang && r_line_start) begin
                    n_phase = mtfc_pkg::PH_END;
                end else if (is_lf) begin
                    if (r_line_cnt < mtfc_pkg::LineTop) begin
                        n_line_cnt = r_line_cnt + 8'd1;
                    end
                    n_col_cnt = '0;
                end else if (!is_cr) begin
                    if (r_col_cnt < mtfc_pkg::ColTop) begin
                        n_col_cnt = r_col_cnt + 12'd1;
                    end
                end
            end
            mtfc_pkg::PH_END, mtfc_pkg::PH_CRC: begin
                if (is_lf) begin
                    n_phase      = mtfc_pkg::PH_TRAILER;
                    n_crc        = '0;
                    n_rx_crc     = '0;
                    n_digit_cnt  = '0;
                    n_parse_stop = 1'b0;
                    n_line_cnt   = '0;
                    n_col_cnt    = '0;
                end else if (!is_cr) begin
                    n_phase = mtfc_pkg::PH_CRC;
                    if (!hex.valid) begin
                        n_parse_stop = 1'b1;
                    end else if (!r_parse_stop && r_digit_cnt < mtfc_pkg::CrcDigits) begin
                        n_rx_crc    = {r_rx_crc[11:0], hex.value};
                        n_digit_cnt = r_digit_cnt + 3'd1;
                    end
                end
            end
            default: begin
                // Idle, trailer and the unused code: a '/' at the start of a line opens a telegram.
                if (is_slash && r_line_start) begin
                    n_crc   = crc_upd;
                    n_phase = mtfc_pkg::PH_HEADER;
                end
            end
        endcase
    end

    // Event for the current byte
    always_comb begin
        n_emit = 1'b0;
        n_kind = mtfc_pkg::EV_UNEXPECTED;
        n_col  = r_col_cnt;
        n_ccrc = '0;
        n_rcrc = '0;
        case (r_phase)
            mtfc_pkg::PH_HEADER: begin
                n_emit = 1'b0;
            end
            mtfc_pkg::PH_SEPARATOR: begin
                n_emit = !is_lf && !is_cr;
            end
            mtfc_pkg::PH_DATA: begin
                if (is_bang && r_line_start) begin
                    n_emit = 1'b0;
                end else if (is_lf) begin
                    n_emit = 1'b1;
                    n_kind = mtfc_pkg::EV_LINE_END;
                end else if (!is_cr) begin
                    n_emit = 1'b1;
                    n_kind = mtfc_pkg::EV_PAYLOAD;
                end
            end
            mtfc_pkg::PH_END, mtfc_pkg::PH_CRC: begin
                if (is_lf) begin
                    n_emit = 1'b1;
                    n_kind = crc_ok ? mtfc_pkg::EV_ACCEPT : mtfc_pkg::EV_MISMATCH;
                    n_col  = '0;
                    n_ccrc = r_crc;
                    n_rcrc = r_rx_crc;
                end
            end
            mtfc_pkg::PH_TRAILER: begin
                n_emit = !is_slash;
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_bypass <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_crc_bypass <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mtfc_pkg::PH_IDLE;
            r_line_start <= 1'b1;
            r_crc        <= '0;
            r_rx_crc     <= '0;
            r_digit_cnt  <= '0;
            r_parse_stop <= 1'b0;
            r_line_cnt   <= '0;
            r_col_cnt    <= '0;
        end else if (do_step) begin
            r_phase      <= n_phase;
            r_line_start <= is_lf || is_cr;
            r_crc        <= n_crc;
            r_rx_crc     <= n_rx_crc;
            r_digit_cnt  <= n_digit_cnt;
            r_parse_stop <= n_parse_stop;
            r_line_cnt   <= n_line_cnt;
            r_col_cnt    <= n_col_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step && n_emit) begin
            r_out_kind <= n_kind;
            r_out_byte <= b;
            r_out_line <= r_line_cnt;
            r_out_col  <= n_col;
            r_out_ccrc <= n_ccrc;
            r_out_rcrc <= n_rcrc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {4'h0, r_out_rcrc, r_out_ccrc, r_out_col, r_out_line, r_out_byte};

    // The hex parser never takes more than four digits.
    `ASSERT_IMPL(a_digit_limit, i_clk, i_rst_n, 1'b1, r_digit_cnt <= mtfc_pkg::CrcDigits,
        "CRC digit count exceeds four")

    // Verdict events carry a zero column; all others carry zero CRC fields.
    `ASSERT_IMPL(a_verdict_col, i_clk, i_rst_n,
        r_out_valid && (r_out_kind == mtfc_pkg::EV_ACCEPT || r_out_kind == mtfc_pkg::EV_MISMATCH),
        r_out_col == '0, "verdict event with nonzero column")

    `ASSERT_IMPL(a_crc_fields, i_clk, i_rst_n,
        r_out_valid && r_out_kind != mtfc_pkg::EV_ACCEPT && r_out_kind != mtfc_pkg::EV_MISMATCH,
        r_out_ccrc == '0 && r_out_rcrc == '0, "CRC fields set on a non-verdict event")

    // A verdict closes the telegram with cleared counters.
    `ASSERT_NEXT(a_close, i_clk, i_rst_n,
        do_step && n_emit && (n_kind == mtfc_pkg::EV_ACCEPT || n_kind == mtfc_pkg::EV_MISMATCH),
        r_phase == mtfc_pkg::PH_TRAILER && r_crc == '0 && r_line_cnt == '0,
        "telegram state not cleared after verdict")

endmodule
